[hw/rtl/midpoint_line_raster_defines.svh]
// Assertion macros shared by the line rasterizer RTL.
`ifndef MIDPOINT_LINE_RASTER_DEFINES_SVH
`define MIDPOINT_LINE_RASTER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define MLR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mlr_pkg.sv]
// Shared types and constants of the line rasterizer.
package mlr_pkg;

  localparam int DIM_BITS      = 13;
  localparam int COLOR_BITS    = 32;
  localparam int ADDR_BITS     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FB_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FB_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MARKER_COLOR = 2'd2;

  localparam logic [DIM_BITS-1:0]   FB_WIDTH_RESET  = 13'd512;
  localparam logic [DIM_BITS-1:0]   FB_HEIGHT_RESET = 13'd512;
  localparam logic [COLOR_BITS-1:0] MARKER_RESET    = 32'h00FF_FF00;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef struct packed {
    logic [DIM_BITS-1:0]   fb_width;
    logic [DIM_BITS-1:0]   fb_height;
    logic [COLOR_BITS-1:0] marker_color;
  } cfg_t;

  // Endpoint orderings found by the front end.
  typedef struct packed {
    logic gt_x;
    logic lt_x;
    logic gt_y;
    logic lt_y;
  } order_t;

endpackage

[hw/rtl/mlr_fifo.sv]
// Small show-ahead FIFO; DEPTH must be a power of two, at least 2.
module mlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr_r;
  logic [AW:0]      rd_ptr_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                   (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/mlr_front.sv]
// Front end: accepts input items and classifies endpoint geometry.
module mlr_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_action,
  input  logic [COORD_BITS-1:0]          in_start_x,
  input  logic [COORD_BITS-1:0]          in_start_y,
  input  logic [COORD_BITS-1:0]          in_end_x,
  input  logic [COORD_BITS-1:0]          in_end_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0] in_line_color,
  output logic                           cmd_push,
  output logic [1+mlr_pkg::COLOR_BITS+6*COORD_BITS+4-1:0] cmd_data,
  input  logic                           cmd_full
);

  mlr_pkg::order_t       ord;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  always_comb begin
    ord.gt_x = in_start_x > in_end_x;
    ord.lt_x = in_start_x < in_end_x;
    ord.gt_y = in_start_y > in_end_y;
    ord.lt_y = in_start_y < in_end_y;
  end

  assign dx = ord.gt_x ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
  assign dy = ord.gt_y ? (in_start_y - in_end_y) : (in_end_y - in_start_y);

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;
  assign cmd_data = {in_action, in_line_color, in_start_x, in_start_y,
                     in_end_x, in_end_y, dx, dy, ord};

endmodule

[hw/rtl/mlr_back.sv]
// Back end: line state, midpoint decision stepping and pixel formatting.
`include "midpoint_line_raster_defines.svh"

module mlr_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlr_pkg::cfg_t        cfg,
  input  logic [1+mlr_pkg::COLOR_BITS+6*COORD_BITS+4-1:0] cmd_data,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output logic [2*COORD_BITS+mlr_pkg::COLOR_BITS+mlr_pkg::ADDR_BITS+2-1:0] res_data,
  output logic                 res_push,
  input  logic                 res_full
);

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 3;
  localparam int SW = (C + mlr_pkg::DIM_BITS + 1 > mlr_pkg::ADDR_BITS) ?
                      (C + mlr_pkg::DIM_BITS + 1) : mlr_pkg::ADDR_BITS;

  typedef enum logic [1:0] {PH_IDLE, PH_LINE, PH_START, PH_END} phase_t;

  // command fields
  logic                           cmd_action;
  logic [mlr_pkg::COLOR_BITS-1:0] cmd_color;
  logic [C-1:0]                   cmd_sx, cmd_sy, cmd_ex, cmd_ey, cmd_dx, cmd_dy;
  mlr_pkg::order_t                cmd_ord;

  assign {cmd_action, cmd_color, cmd_sx, cmd_sy, cmd_ex, cmd_ey,
          cmd_dx, cmd_dy, cmd_ord} = cmd_data;

  // line state
  phase_t                         phase_r, phase_nxt;
  logic [C-1:0]                   major_pos_r, major_nxt;
  logic [C-1:0]                   minor_pos_r, minor_nxt;
  logic [C-1:0]                   major_end_r;
  logic signed [DW-1:0]           decision_r, decision_nxt;
  logic signed [DW-1:0]           step_up_r;
  logic signed [DW-1:0]           step_flat_r;
  logic                           y_major_r;
  logic                           minor_neg_r;
  logic [C-1:0]                   sx_r, sy_r, ex_r, ey_r;
  logic [mlr_pkg::COLOR_BITS-1:0] color_r;

  // pixel stage
  logic                           pix_v_r, pix_v_nxt;
  logic                           pix_ok_r, pix_ok_nxt;
  logic                           pix_last_r, pix_last_nxt;
  logic [C-1:0]                   pix_x_r, pix_x_nxt;
  logic [C-1:0]                   pix_y_r, pix_y_nxt;
  logic [mlr_pkg::COLOR_BITS-1:0] pix_color_r, pix_color_nxt;

  logic adv, load_pop, step_pop;

  assign adv      = !pix_v_r || !res_full;
  assign load_pop = !cmd_empty && (cmd_action == mlr_pkg::ACT_LOAD);
  assign step_pop = !cmd_empty && (cmd_action == mlr_pkg::ACT_STEP) && adv;
  assign cmd_pop  = load_pop || step_pop;

  // load classification: order along the major axis
  logic                 ld_ymaj, ld_swap, ld_neg;
  logic [C-1:0]         ld_dmaj, ld_dmin, ld_a0, ld_a1, ld_b0;
  logic signed [DW-1:0] ld_dec, ld_up, ld_flat;

  always_comb begin
    ld_ymaj = cmd_dy > cmd_dx;
    ld_dmaj = ld_ymaj ? cmd_dy : cmd_dx;
    ld_dmin = ld_ymaj ? cmd_dx : cmd_dy;
    ld_swap = ld_ymaj ? cmd_ord.gt_y : cmd_ord.gt_x;
    if (ld_ymaj) begin
      ld_a0  = ld_swap ? cmd_ey : cmd_sy;
      ld_a1  = ld_swap ? cmd_sy : cmd_ey;
      ld_b0  = ld_swap ? cmd_ex : cmd_sx;
      ld_neg = ld_swap ? cmd_ord.lt_x : cmd_ord.gt_x;
    end else begin
      ld_a0  = ld_swap ? cmd_ex : cmd_sx;
      ld_a1  = ld_swap ? cmd_sx : cmd_ex;
      ld_b0  = ld_swap ? cmd_ey : cmd_sy;
      ld_neg = ld_swap ? cmd_ord.lt_y : cmd_ord.gt_y;
    end
    ld_flat = DW'(ld_dmin) <<< 1;
    ld_dec  = ld_flat - DW'(ld_dmaj);
    ld_up   = (DW'(ld_dmin) - DW'(ld_dmaj)) <<< 1;
  end

  logic line_done, dec_pos;

  assign line_done = (major_pos_r == major_end_r);
  assign dec_pos   = !decision_r[DW-1] && (decision_r != '0);

  always_comb begin
    phase_nxt     = phase_r;
    major_nxt     = major_pos_r;
    minor_nxt     = minor_pos_r;
    decision_nxt  = decision_r;
    pix_ok_nxt    = 1'b1;
    pix_last_nxt  = 1'b0;
    pix_x_nxt     = '0;
    pix_y_nxt     = '0;
    pix_color_nxt = '0;
    case (phase_r)
      PH_LINE: begin
        pix_x_nxt     = y_major_r ? minor_pos_r : major_pos_r;
        pix_y_nxt     = y_major_r ? major_pos_r : minor_pos_r;
        pix_color_nxt = color_r;
      end
      PH_START: begin
        pix_x_nxt     = sx_r;
        pix_y_nxt     = sy_r;
        pix_color_nxt = cfg.marker_color;
      end
      PH_END: begin
        pix_x_nxt     = ex_r;
        pix_y_nxt     = ey_r;
        pix_color_nxt = cfg.marker_color;
        pix_last_nxt  = 1'b1;
      end
      default: begin
        pix_ok_nxt   = 1'b0;
        pix_last_nxt = 1'b1;
      end
    endcase

    if (load_pop) begin
      phase_nxt    = PH_LINE;
      major_nxt    = ld_a0;
      minor_nxt    = ld_b0;
      decision_nxt = ld_dec;
    end else if (step_pop) begin
      case (phase_r)
        PH_LINE: begin
          if (line_done) begin
            phase_nxt = PH_START;
          end else begin
            major_nxt = major_pos_r + 1'b1;
            if (dec_pos) begin
              minor_nxt    = minor_neg_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
              decision_nxt = decision_r + step_up_r;
            end else begin
              decision_nxt = decision_r + step_flat_r;
            end
          end
        end
        PH_START: phase_nxt = PH_END;
        PH_END:   phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    if (step_pop) begin
      pix_v_nxt = 1'b1;
    end else if (res_push) begin
      pix_v_nxt = 1'b0;
    end else begin
      pix_v_nxt = pix_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pix_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pix_v_r <= pix_v_nxt;
    end
    major_pos_r <= major_nxt;
    minor_pos_r <= minor_nxt;
    decision_r  <= decision_nxt;
    if (load_pop) begin
      major_end_r <= ld_a1;
      step_up_r   <= ld_up;
      step_flat_r <= ld_flat;
      y_major_r   <= ld_ymaj;
      minor_neg_r <= ld_neg;
      sx_r        <= cmd_sx;
      sy_r        <= cmd_sy;
      ex_r        <= cmd_ex;
      ey_r        <= cmd_ey;
      color_r     <= cmd_color;
    end
    if (step_pop) begin
      pix_ok_r    <= pix_ok_nxt;
      pix_last_r  <= pix_last_nxt;
      pix_x_r     <= pix_x_nxt;
      pix_y_r     <= pix_y_nxt;
      pix_color_r <= pix_color_nxt;
    end
  end

  // address and clip from the registered pixel
  logic [SW-1:0]                 addr_sum;
  logic [mlr_pkg::ADDR_BITS-1:0] pix_addr;
  logic                          pix_we;

  assign addr_sum = SW'(pix_y_r) * SW'(cfg.fb_width) + SW'(pix_x_r);
  assign pix_addr = pix_ok_r ? addr_sum[mlr_pkg::ADDR_BITS-1:0] : '0;
  assign pix_we   = pix_ok_r && (SW'(pix_x_r) < SW'(cfg.fb_width)) &&
                    (SW'(pix_y_r) < SW'(cfg.fb_height));
  assign res_push = pix_v_r && !res_full;
  assign res_data = {pix_x_r, pix_y_r, pix_color_r, pix_addr, pix_we, pix_last_r};

  `MLR_ASSERT_NEXT(a_load_starts_line, load_pop, phase_r == PH_LINE, "load did not start a line")
  `MLR_ASSERT_NEXT(a_line_to_marker, step_pop && (phase_r == PH_LINE) && line_done,
                   phase_r == PH_START, "line end did not move to start marker")
  `MLR_ASSERT_NEXT(a_end_marker_last, step_pop && (phase_r == PH_END),
                   pix_v_r && pix_ok_r && pix_last_r, "end marker lacks last flag")
  `MLR_ASSERT_NEXT(a_pixel_holds, pix_v_r && res_full,
                   pix_v_r && $stable(pix_x_r) && $stable(pix_color_r),
                   "stalled pixel changed")
  `MLR_ASSERT_IMPLY(a_one_pop_kind, cmd_pop, !(load_pop && step_pop),
                    "load and step popped together")

endmodule

[hw/rtl/midpoint_line_raster.sv]
// Midpoint line rasterizer top level: configuration, queues and pipeline.
//
// A load item (action 0) latches two endpoints and a line color and gives no
// result; every step item (action 1) gives one pixel write: the line pixels
// in order along the major axis (x-major for diagonals), then a start marker
// and an end marker in the marker color, the end marker flagged last. A step
// with no active line gives a clipped pixel at the origin flagged last.
// Items are taken one per clock and results leave one per clock while neither
// queue backs up: the back end advances the midpoint decision (one add and a
// sign test) once per step item, and that loop sets the rate. A step item
// passes the command queue, the pixel register and the result queue on its
// way to the result ports. The address is y * fb_width + x,
// modulo 2^24, from one multiply of y by the 13-bit width after the pixel
// register. Write configuration only while no item is in flight.
module midpoint_line_raster #(
  parameter int COORD_BITS = 12,
  parameter int CMD_DEPTH  = 2,
  parameter int RES_DEPTH  = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_action,
  input  logic [COORD_BITS-1:0]             in_start_x,
  input  logic [COORD_BITS-1:0]             in_start_y,
  input  logic [COORD_BITS-1:0]             in_end_x,
  input  logic [COORD_BITS-1:0]             in_end_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0]    in_line_color,
  // result channel
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [COORD_BITS-1:0]             out_pixel_x,
  output logic [COORD_BITS-1:0]             out_pixel_y,
  output logic [mlr_pkg::COLOR_BITS-1:0]    out_pixel_color,
  output logic [mlr_pkg::ADDR_BITS-1:0]     out_pixel_addr,
  output logic                              out_write_enable,
  output logic                              out_last,
  // configuration
  input  logic                              cfg_we,
  input  logic [mlr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mlr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CMD_W = 1 + mlr_pkg::COLOR_BITS + 6 * COORD_BITS + 4;
  localparam int RES_W = 2 * COORD_BITS + mlr_pkg::COLOR_BITS + mlr_pkg::ADDR_BITS + 2;

  // Configuration registers; an index past the list is dropped.
  mlr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width     <= mlr_pkg::FB_WIDTH_RESET;
      cfg_r.fb_height    <= mlr_pkg::FB_HEIGHT_RESET;
      cfg_r.marker_color <= mlr_pkg::MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mlr_pkg::CFG_FB_WIDTH:     cfg_r.fb_width     <= cfg_data[mlr_pkg::DIM_BITS-1:0];
        mlr_pkg::CFG_FB_HEIGHT:    cfg_r.fb_height    <= cfg_data[mlr_pkg::DIM_BITS-1:0];
        mlr_pkg::CFG_MARKER_COLOR: cfg_r.marker_color <= cfg_data[mlr_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end classifies each item and pushes it into the command queue.
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

  mlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_color (in_line_color),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_wdata),
    .cmd_full      (cmd_full)
  );

  // Command queue decouples acceptance from the stepping back end.
  mlr_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // Back end steps the line and formats one pixel per step transfer.
  logic             res_push, res_full;
  logic [RES_W-1:0] res_wdata, res_rdata;

  mlr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_data  (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_data  (res_wdata),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue holds finished pixels while the consumer stalls.
  mlr_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign {out_pixel_x, out_pixel_y, out_pixel_color, out_pixel_addr,
          out_write_enable, out_last} = res_rdata;

endmodule

[verif/midpoint_line_raster_pixel_check.sv]
// Pixel predictor and result comparator for the midpoint line rasterizer test.
module midpoint_line_raster_pixel_check #(
  parameter int COORD_W = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic                              in_action,
  input  logic [COORD_W-1:0]                in_start_x,
  input  logic [COORD_W-1:0]                in_start_y,
  input  logic [COORD_W-1:0]                in_end_x,
  input  logic [COORD_W-1:0]                in_end_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0]    in_line_color,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic [COORD_W-1:0]                out_pixel_x,
  input  logic [COORD_W-1:0]                out_pixel_y,
  input  logic [mlr_pkg::COLOR_BITS-1:0]    out_pixel_color,
  input  logic [mlr_pkg::ADDR_BITS-1:0]     out_pixel_addr,
  input  logic                              out_write_enable,
  input  logic                              out_last,
  input  logic                              cfg_we,
  input  logic [mlr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mlr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                mismatches,
  output int                                pixels_pending,
  output int                                pixels_checked,
  output int                                pixels_clipped
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W  = mlr_pkg::ADDR_BITS;
  localparam int COLOR_W = mlr_pkg::COLOR_BITS;
  localparam int DIM_W   = mlr_pkg::DIM_BITS;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic [ADDR_W-1:0]  addr;
    logic               we;
    logic               last;
  } pixel_t;

  typedef enum logic [1:0] {
    RS_IDLE,
    RS_LINE,
    RS_START_MARK,
    RS_END_MARK
  } raster_phase_t;

  // Shadow of the configuration registers.
  logic [DIM_W-1:0]   fb_w;
  logic [DIM_W-1:0]   fb_h;
  logic [COLOR_W-1:0] marker;

  // Shadow of the rasterizer state.
  raster_phase_t      phase;
  logic [COORD_W-1:0] major_pos, minor_pos, major_stop;
  logic signed [27:0] decision;
  logic [12:0]        d_major, d_minor;
  logic               y_major, step_down;
  logic [COORD_W-1:0] first_x, first_y, far_x, far_y;
  logic [COLOR_W-1:0] color_q;

  pixel_t pixel_q[$];

  function automatic pixel_t make_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [COLOR_W-1:0] color, logic last);
    pixel_t p;
    p.x     = x;
    p.y     = y;
    p.color = color;
    p.addr  = ADDR_W'(32'(y) * 32'(fb_w) + 32'(x));
    p.we    = (32'(x) < 32'(fb_w)) && (32'(y) < 32'(fb_h));
    p.last  = last;
    return p;
  endfunction

  task automatic latch_line();
    logic [COORD_W-1:0] a0, a1, b0, b1, t;
    logic [12:0]        dx, dy;
    dx = (in_start_x > in_end_x) ? 13'(in_start_x - in_end_x) : 13'(in_end_x - in_start_x);
    dy = (in_start_y > in_end_y) ? 13'(in_start_y - in_end_y) : 13'(in_end_y - in_start_y);
    first_x = in_start_x;
    first_y = in_start_y;
    far_x   = in_end_x;
    far_y   = in_end_y;
    color_q = in_line_color;
    // diagonals stay x-major
    y_major = dy > dx;
    if (y_major) begin
      a0 = in_start_y; a1 = in_end_y; b0 = in_start_x; b1 = in_end_x;
      d_major = dy; d_minor = dx;
    end else begin
      a0 = in_start_x; a1 = in_end_x; b0 = in_start_y; b1 = in_end_y;
      d_major = dx; d_minor = dy;
    end
    // walk with the major coordinate increasing
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    major_pos  = a0;
    major_stop = a1;
    minor_pos  = b0;
    step_down  = b1 < b0;
    decision   = 28'(32'(d_minor) * 2 - 32'(d_major));
    phase      = RS_LINE;
  endtask

  task automatic advance_line(output pixel_t p);
    case (phase)
      RS_LINE: begin
        p = make_pixel(y_major ? minor_pos : major_pos, y_major ? major_pos : minor_pos,
                       color_q, 1'b0);
        if (major_pos == major_stop) begin
          phase = RS_START_MARK;
        end else begin
          // a tie keeps the minor coordinate
          if (decision > 0) begin
            minor_pos = step_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
            decision  = decision + 28'(32'(d_minor) * 2) - 28'(32'(d_major) * 2);
          end else begin
            decision = decision + 28'(32'(d_minor) * 2);
          end
          major_pos = major_pos + 1'b1;
        end
      end
      RS_START_MARK: begin
        p     = make_pixel(first_x, first_y, marker, 1'b0);
        phase = RS_END_MARK;
      end
      RS_END_MARK: begin
        p     = make_pixel(far_x, far_y, marker, 1'b1);
        phase = RS_IDLE;
      end
      default: begin
        p      = '0;
        p.last = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk) begin : track
    pixel_t want, got;
    int     errs;
    errs = 0;
    if (!rst_n) begin
      fb_w      = mlr_pkg::FB_WIDTH_RESET;
      fb_h      = mlr_pkg::FB_HEIGHT_RESET;
      marker    = mlr_pkg::MARKER_RESET;
      phase     = RS_IDLE;
      major_pos = '0; minor_pos = '0; major_stop = '0;
      decision  = '0; d_major = '0; d_minor = '0;
      y_major   = 1'b0; step_down = 1'b0;
      first_x   = '0; first_y = '0; far_x = '0; far_y = '0;
      color_q   = '0;
      pixel_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        got = '{out_pixel_x, out_pixel_y, out_pixel_color, out_pixel_addr,
                out_write_enable, out_last};
        if (pixel_q.size() == 0) begin
          $error("pixel transfer with nothing expected: x=%0d y=%0d", got.x, got.y);
          errs++;
        end else begin
          want = pixel_q.pop_front();
          if (got.x != want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, got.x); errs++;
          end
          if (got.y != want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, got.y); errs++;
          end
          if (got.color != want.color) begin
            $error("pixel_color: expected %08h, got %08h", want.color, got.color); errs++;
          end
          if (got.addr != want.addr) begin
            $error("pixel_addr: expected %0d, got %0d", want.addr, got.addr); errs++;
          end
          if (got.we != want.we) begin
            $error("write_enable: expected %0b, got %0b", want.we, got.we); errs++;
          end
          if (got.last != want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last); errs++;
          end
        end
        pixels_checked <= pixels_checked + 1;
        if (!got.we) pixels_clipped <= pixels_clipped + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          mlr_pkg::CFG_FB_WIDTH:     fb_w   = cfg_data[DIM_W-1:0];
          mlr_pkg::CFG_FB_HEIGHT:    fb_h   = cfg_data[DIM_W-1:0];
          mlr_pkg::CFG_MARKER_COLOR: marker = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_action == mlr_pkg::ACT_LOAD) begin
          latch_line();
        end else begin
          advance_line(want);
          pixel_q.push_back(want);
        end
      end
    end
    mismatches     <= mismatches + errs;
    pixels_pending <= pixel_q.size();
  end

endmodule

[verif/midpoint_line_raster_test.sv]
// Top of the line rasterizer test: clock, reset, stimulus, flow control and verdict.
module midpoint_line_raster_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = 12;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int COLOR_W    = mlr_pkg::COLOR_BITS;
  localparam int CFG_W      = mlr_pkg::CFG_DATA_BITS;
  // cycles with no transfer on either side before the run is called hung
  localparam int STALL_LIMIT = 1000;
  // a result passes the command queue, the pixel register and the result queue; leave room for all
  localparam int SETTLE = 8;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_push;
  logic                             in_full;
  logic                             in_action;
  logic [COORD_W-1:0]               in_start_x, in_start_y, in_end_x, in_end_y;
  logic [COLOR_W-1:0]               in_line_color;
  logic                             out_empty;
  logic                             out_pop = 1'b1;
  logic [COORD_W-1:0]               out_pixel_x, out_pixel_y;
  logic [COLOR_W-1:0]               out_pixel_color;
  logic [mlr_pkg::ADDR_BITS-1:0]    out_pixel_addr;
  logic                             out_write_enable;
  logic                             out_last;
  logic                             cfg_we;
  logic [mlr_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_W-1:0]                 cfg_data;

  int    mismatches, pixels_pending, pixels_checked, pixels_clipped;
  flow_t flow = FLOW_FREE;
  int    items_sent  = 0;
  int    lines_drawn = 0;
  int    stall_cycles = 0;
  int    cur_w = 512;
  int    cur_h = 512;

  always #10 clk = ~clk;

  midpoint_line_raster dut (
    .clk, .rst_n,
    .in_push, .in_full, .in_action, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .in_line_color,
    .out_empty, .out_pop, .out_pixel_x, .out_pixel_y, .out_pixel_color, .out_pixel_addr,
    .out_write_enable, .out_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  midpoint_line_raster_pixel_check #(.COORD_W(COORD_W)) pixel_check (
    .clk, .rst_n,
    .in_push, .in_full, .in_action, .in_start_x, .in_start_y, .in_end_x, .in_end_y,
    .in_line_color,
    .out_empty, .out_pop, .out_pixel_x, .out_pixel_y, .out_pixel_color, .out_pixel_addr,
    .out_write_enable, .out_last,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pixels_pending, .pixels_checked, .pixels_clipped
  );

  // Receiver side: pop freely, or stall on a random share of cycles.
  always @(posedge clk) begin
    case (flow)
      FLOW_RECEIVER_STALLS: out_pop <= $urandom_range(0, 99) >= 79;
      FLOW_BOTH:            out_pop <= $urandom_range(0, 99) >= 20;
      default:              out_pop <= 1'b1;
    endcase
  end

  // Watchdog: any transfer on either side proves progress.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("midpoint_line_raster_test failed");
      $finish;
    end
  end

  // Sender side: decide whether to keep holding off the next item.
  function automatic bit sender_gap();
    case (flow)
      FLOW_SENDER_GAPS: return $urandom_range(0, 99) < 79;
      FLOW_BOTH:        return $urandom_range(0, 99) < 20;
      default:          return 1'b0;
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Push stays high
  // afterwards so back-to-back items go out without a bubble.
  task automatic send_item(logic act, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                           logic [COLOR_W-1:0] color);
    while (sender_gap()) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_action     <= act;
    in_start_x    <= sx;
    in_start_y    <= sy;
    in_end_x      <= ex;
    in_end_y      <= ey;
    in_line_color <= color;
    do @(posedge clk); while (in_full);
    items_sent++;
    if (act == mlr_pkg::ACT_LOAD) lines_drawn++;
  endtask

  // Load a line, then request a number of pixels. Coordinates on a step are
  // junk on purpose: the block must ignore them.
  task automatic draw_line(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                           logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                           logic [COLOR_W-1:0] color, int steps);
    send_item(mlr_pkg::ACT_LOAD, sx, sy, ex, ey, color);
    repeat (steps) begin
      send_item(mlr_pkg::ACT_STEP,
                COORD_W'($urandom_range(0, COORD_MAX)), COORD_W'($urandom_range(0, COORD_MAX)),
                COORD_W'($urandom_range(0, COORD_MAX)), COORD_W'($urandom_range(0, COORD_MAX)),
                $urandom);
    end
  endtask

  // Drop push, let every expected pixel drain, then let any trailing load settle.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers back to back; the block must be idle.
  task automatic write_settings(int w, int h, logic [COLOR_W-1:0] color);
    cfg_we    <= 1'b1;
    cfg_index <= mlr_pkg::CFG_FB_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(posedge clk);
    cfg_index <= mlr_pkg::CFG_FB_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(posedge clk);
    cfg_index <= mlr_pkg::CFG_MARKER_COLOR;
    cfg_data  <= color;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Coordinate a short distance from c, kept inside the coordinate range.
  function automatic logic [COORD_W-1:0] offset_from(int c, int d);
    if (c + d <= COORD_MAX && ($urandom_range(0, 1) == 1 || c < d)) return COORD_W'(c + d);
    return COORD_W'(c - d);
  endfunction

  // Coordinate straddling a clip limit.
  function automatic logic [COORD_W-1:0] near_clip(int lim);
    int v;
    v = lim - 3 + $urandom_range(0, 5);
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_W'(v);
  endfunction

  // Random lines until the item count reaches goal. Most are complete short
  // lines; the rest are abandoned early, over-stepped into idle, or long
  // lines cut off by the next load.
  task automatic random_lines(int goal);
    int kind, reach, dx, dy, steps;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    while (items_sent < goal) begin
      kind = $urandom_range(0, 19);
      sx = COORD_W'($urandom_range(0, COORD_MAX));
      sy = COORD_W'($urandom_range(0, COORD_MAX));
      if (kind == 5) begin
        sx = near_clip(cur_w);
        sy = near_clip(cur_h);
      end
      reach = (kind < 3) ? 40 : 10;
      dx = $urandom_range(0, reach);
      dy = (kind == 3) ? dx : (kind == 4) ? 0 : $urandom_range(0, reach);
      ex = offset_from(int'(sx), dx);
      ey = offset_from(int'(sy), dy);
      steps = ((dx > dy) ? dx : dy) + 3;
      if (kind == 0) begin
        ex = COORD_W'($urandom_range(0, COORD_MAX));
        ey = COORD_W'($urandom_range(0, COORD_MAX));
        steps = $urandom_range(1, 8);
      end else if (kind == 1) begin
        steps = $urandom_range(0, steps - 1);
      end else if (kind == 2) begin
        steps += $urandom_range(1, 3);
      end
      draw_line(sx, sy, ex, ey, $urandom, steps);
      // now and then hold the sender until the result side runs dry
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  task automatic run_phase(int w, int h, logic [COLOR_W-1:0] color, flow_t mode, int n);
    drain();
    write_settings(w, h, color);
    flow <= mode;
    random_lines(items_sent + n);
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_push       <= 1'b0;
    in_action     <= mlr_pkg::ACT_LOAD;
    in_start_x    <= '0;
    in_start_y    <= '0;
    in_end_x      <= '0;
    in_end_y      <= '0;
    in_line_color <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= mlr_pkg::CFG_FB_WIDTH;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines under the reset settings (512 x 512).
    // Step with no line loaded: clipped origin flagged last.
    send_item(mlr_pkg::ACT_STEP, '1, '1, '1, '1, '1);
    // Zero-length line at the far corner, clipped, then one step past the end.
    draw_line(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), COORD_W'(COORD_MAX),
              COORD_W'(COORD_MAX), 32'hFFFF_FFFF, 4);
    // Reversed diagonal: x-major, endpoints swapped, minor coordinate falling.
    draw_line(3, 0, 0, 3, 32'h0000_0000, 6);
    // Steep line abandoned after two pixels.
    draw_line(0, 0, 1, 4, 32'hA5A5_A5A5, 2);
    // Decision lands exactly on zero at the first step.
    draw_line(0, 0, 2, 1, 32'h5A5A_5A5A, 5);
    // Diagonal across the clip corner.
    draw_line(512, 511, 511, 512, 32'h1234_5678, 4);

    // Random phases: each one changes the settings while idle and picks a flow mix.
    run_phase(4096, 4096, 32'hFFFF_FFFF, FLOW_FREE,            105);
    run_phase(1,    1,    32'h0000_0000, FLOW_SENDER_GAPS,     105);
    run_phase(0,    300,  $urandom,      FLOW_RECEIVER_STALLS, 105);
    run_phase(8191, 8191, $urandom,      FLOW_BOTH,            105);
    run_phase(640,  0,    $urandom,      FLOW_FREE,            105);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom,
              FLOW_SENDER_GAPS, 105);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom,
              FLOW_RECEIVER_STALLS, 105);
    run_phase(512,  512,  mlr_pkg::MARKER_RESET, FLOW_BOTH,    105);

    drain();
    $display("Covered %0d items in %0d line loads across nine framebuffer settings",
             items_sent, lines_drawn);
    $display("and four flow mixes; %0d pixel transfers compared, %0d of them clipped.",
             pixels_checked, pixels_clipped);
    if (mismatches == 0 && pixels_pending == 0) begin
      $display("midpoint_line_raster_test passed");
    end else begin
      $display("midpoint_line_raster_test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_fifo.sv
hw/rtl/mlr_front.sv
hw/rtl/mlr_back.sv
hw/rtl/midpoint_line_raster.sv
verif/midpoint_line_raster_pixel_check.sv
verif/midpoint_line_raster_test.sv
